>>> src/iks_pkg.sv
// Package for the key sorter: widths, store size, command and status codes,
// and the sequencer state type. Used by id_key_sorter; depends on nothing.
package iks_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int STORE_DEPTH = 64;
	localparam int KEY_W       = 32;
	localparam int SLOT_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
	localparam int CMD_W       = 2;
	localparam int STAT_W      = 2;
	localparam int IN_DATA_W   = ((KEY_W + 7) / 8) * 8;
	localparam int OUT_DATA_W  = ((SLOT_W + KEY_W + 7) / 8) * 8;

	localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_SORT  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [STAT_W-1:0] STAT_ACCEPTED = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
	localparam logic [STAT_W-1:0] STAT_SORTED   = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd3;

	typedef enum logic [3:0] {
		ST_IDLE  = 4'b0001,
		ST_SCAN  = 4'b0010,
		ST_DRAIN = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

endpackage

>>> src/id_key_sorter.sv
// Key sorter: stores keys in insertion slots and emits them in ascending
// (key, slot) order. Depends on iks_pkg for widths, codes and state type.
// Add, clear and empty sort finish in the cycle after acceptance; clear emits no result.
// A sort of n entries runs n selection passes over the key memory; a pass makes
// one memory read per cycle in ST_SCAN, checks the last read in ST_DRAIN and
// emits in ST_EMIT, which waits on a held output; the single read port sets this.
// Throughput: one command at a time; s_tready is low while a sort runs or the output is stalled.
// Reset clears the entry count and the sequencer; key memory is not cleared.
module id_key_sorter (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [iks_pkg::IN_DATA_W-1:0]     s_tdata,  // [31:0] key, rest zero
	input  logic [iks_pkg::CMD_W-1:0]         s_tuser,  // [1:0] cmd
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [iks_pkg::OUT_DATA_W-1:0]    m_tdata,  // [5:0] slot, [37:6] sorted_key
	output logic [iks_pkg::STAT_W-1:0]        m_tuser,  // [1:0] status
	output logic                              m_tlast
);
	import iks_pkg::*;

	logic [KEY_W-1:0]  mem [STORE_DEPTH];
	logic [KEY_W-1:0]  rd_data_q;
	logic [SLOT_W-1:0] slot_s1;
	logic              rd_vld_s1;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rank_q;
	logic [SLOT_W-1:0] idx_q;

	logic [KEY_W-1:0]  prev_key_q;
	logic [SLOT_W-1:0] prev_slot_q;
	logic              have_prev_q;
	logic [KEY_W-1:0]  best_key_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic              best_valid_q;

	logic              out_valid_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [KEY_W-1:0]  out_key_q;
	logic [STAT_W-1:0] out_stat_q;
	logic              out_last_q;

	logic                    out_free;
	logic                    in_fire;
	logic [CMD_W-1:0]        cmd;
	logic [KEY_W-1:0]        key;
	logic                    full;
	logic                    do_write;
	logic [KEY_W+SLOT_W-1:0] cand;
	logic                    cand_take;
	logic                    pass_last;
	logic                    emit_last;

	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == ST_IDLE) && out_free;
	assign in_fire   = s_tvalid && s_tready;
	assign cmd       = s_tuser;
	assign key       = s_tdata[KEY_W-1:0];
	assign full      = count_q >= CNT_W'(MAX_ENTRIES);
	assign do_write  = in_fire && (cmd == CMD_ADD) && !full;

	// Candidate must lie above the last emitted entry and below the best so far.
	assign cand      = {rd_data_q, slot_s1};
	assign cand_take = rd_vld_s1
		&& (!have_prev_q || cand > {prev_key_q, prev_slot_q})
		&& (!best_valid_q || cand < {best_key_q, best_slot_q});
	assign pass_last = ({1'b0, idx_q} + CNT_W'(1)) == count_q;
	assign emit_last = (rank_q + CNT_W'(1)) == count_q;

	always_ff @(posedge clk) begin
		if (do_write) begin
			mem[count_q[SLOT_W-1:0]] <= key;
		end
		rd_data_q <= mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			rank_q       <= '0;
			idx_q        <= '0;
			rd_vld_s1    <= 1'b0;
			have_prev_q  <= 1'b0;
			best_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cand_take) begin
				best_valid_q <= 1'b1;
			end
			case (state_q)
				ST_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (in_fire) begin
						case (cmd)
							CMD_ADD: begin
								out_valid_q <= 1'b1;
								if (!full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							CMD_SORT: begin
								idx_q        <= '0;
								rank_q       <= '0;
								have_prev_q  <= 1'b0;
								best_valid_q <= 1'b0;
								if (count_q == '0) begin
									out_valid_q <= 1'b1;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_SCAN: begin
					rd_vld_s1 <= 1'b1;
					idx_q     <= idx_q + SLOT_W'(1);
					if (pass_last) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					// Compare the final read of the pass.
					rd_vld_s1 <= 1'b0;
					state_q   <= ST_EMIT;
				end
				ST_EMIT: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						have_prev_q  <= 1'b1;
						best_valid_q <= 1'b0;
						rank_q       <= rank_q + CNT_W'(1);
						idx_q        <= '0;
						state_q      <= emit_last ? ST_IDLE : ST_SCAN;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= idx_q;
		if (cand_take) begin
			best_key_q  <= rd_data_q;
			best_slot_q <= slot_s1;
		end
		if (state_q == ST_EMIT && out_free) begin
			prev_key_q  <= best_key_q;
			prev_slot_q <= best_slot_q;
			out_stat_q  <= STAT_SORTED;
			out_slot_q  <= best_slot_q;
			out_key_q   <= best_key_q;
			out_last_q  <= emit_last;
		end else if (in_fire && cmd == CMD_ADD) begin
			out_last_q <= 1'b1;
			if (full) begin
				out_stat_q <= STAT_FULL;
				out_slot_q <= '0;
				out_key_q  <= '0;
			end else begin
				out_stat_q <= STAT_ACCEPTED;
				out_slot_q <= count_q[SLOT_W-1:0];
				out_key_q  <= key;
			end
		end else if (in_fire && cmd == CMD_SORT) begin
			out_last_q <= 1'b1;
			out_stat_q <= STAT_EMPTY;
			out_slot_q <= '0;
			out_key_q  <= '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_DATA_W - SLOT_W - KEY_W){1'b0}}, out_key_q, out_slot_q};
	assign m_tuser  = out_stat_q;
	assign m_tlast  = out_last_q;

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above capacity");

	a_sort_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> count_q != '0)
		else $error("sort pass running on an empty store");

	a_emit_has_best: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EMIT |-> best_valid_q)
		else $error("selection pass ended without a candidate");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_SCAN |-> ({1'b0, idx_q} < count_q && rank_q < count_q))
		else $error("scan index or rank beyond stored entries");

endmodule

>>> bench/sort_result_checker.sv
// Result checker for id_key_sorter: watches both stream channels, predicts the
// results of every accepted command and compares them. Depends on iks_pkg.
module sort_result_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	input  logic                           s_tready,
	input  logic [iks_pkg::IN_DATA_W-1:0]  s_tdata,   // [31:0] key
	input  logic [iks_pkg::CMD_W-1:0]      s_tuser,   // [1:0] cmd
	input  logic                           m_tvalid,
	input  logic                           m_tready,
	input  logic [iks_pkg::OUT_DATA_W-1:0] m_tdata,   // [5:0] slot, [37:6] sorted_key
	input  logic [iks_pkg::STAT_W-1:0]     m_tuser,   // [1:0] status
	input  logic                           m_tlast,
	output int                             mismatches,
	output int                             outstanding
);
	import iks_pkg::*;

	localparam int CAPACITY = (MAX_ENTRIES < STORE_DEPTH) ? MAX_ENTRIES : STORE_DEPTH;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [SLOT_W-1:0] slot;
		logic [KEY_W-1:0]  key;
		logic              last;
	} entry_result_t;

	logic [KEY_W-1:0] stored_keys [STORE_DEPTH];
	int               stored_count;
	entry_result_t    awaited_results [$];
	entry_result_t    oldest;

	function automatic entry_result_t make_result(logic [STAT_W-1:0] status,
			logic [SLOT_W-1:0] slot, logic [KEY_W-1:0] key, logic last);
		entry_result_t r;
		r.status = status;
		r.slot   = slot;
		r.key    = key;
		r.last   = last;
		return r;
	endfunction

	// Update the shadow store and queue what the command must produce.
	function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
		int order [$];
		int pos;
		case (cmd)
			CMD_ADD: begin
				if (stored_count >= CAPACITY) begin
					awaited_results.push_back(make_result(STAT_FULL, '0, '0, 1'b1));
				end else begin
					stored_keys[stored_count] = key;
					awaited_results.push_back(make_result(STAT_ACCEPTED,
						SLOT_W'(stored_count), key, 1'b1));
					stored_count++;
				end
			end
			CMD_SORT: begin
				if (stored_count == 0) begin
					awaited_results.push_back(make_result(STAT_EMPTY, '0, '0, 1'b1));
				end else begin
					// Insert slots in ascending order behind equal keys: ties stay by slot.
					for (int i = 0; i < stored_count; i++) begin
						pos = order.size();
						while (pos > 0 && stored_keys[order[pos-1]] > stored_keys[i])
							pos--;
						order.insert(pos, i);
					end
					foreach (order[k])
						awaited_results.push_back(make_result(STAT_SORTED, SLOT_W'(order[k]),
							stored_keys[order[k]], k == order.size() - 1));
				end
			end
			CMD_CLEAR: stored_count = 0;
			default: ;
		endcase
	endfunction

	task automatic report(string field, logic [KEY_W-1:0] want, logic [KEY_W-1:0] got);
		if (mismatches < 100)
			$display("mismatch on %s: expected 'h%0h, got 'h%0h", field, want, got);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stored_count = 0;
			mismatches   = 0;
			awaited_results.delete();
			outstanding <= 0;
		end else begin
			if (s_tvalid && s_tready)
				predict_command(s_tuser, s_tdata[KEY_W-1:0]);
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report("unexpected transaction", '0, m_tdata[SLOT_W+KEY_W-1:SLOT_W]);
				end else begin
					oldest = awaited_results.pop_front();
					if (m_tuser !== oldest.status)
						report("status", KEY_W'(oldest.status), KEY_W'(m_tuser));
					if (m_tdata[SLOT_W-1:0] !== oldest.slot)
						report("slot", KEY_W'(oldest.slot), KEY_W'(m_tdata[SLOT_W-1:0]));
					if (m_tdata[SLOT_W+KEY_W-1:SLOT_W] !== oldest.key)
						report("sorted_key", oldest.key, m_tdata[SLOT_W+KEY_W-1:SLOT_W]);
					if (m_tlast !== oldest.last)
						report("last", KEY_W'(oldest.last), KEY_W'(m_tlast));
				end
			end
			// Registered copy: readers at the next edge see a settled count.
			outstanding <= awaited_results.size();
		end
	end

endmodule

>>> bench/testbench.sv
// Testbench top for id_key_sorter: drives commands and output back-pressure,
// then gives the verdict. Depends on iks_pkg and sort_result_checker.
module testbench;
	import iks_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int ITEM_TARGET   = 130;
	localparam int SETTLE_CYCLES = 100;
	// Worst case per item: 64 results behind the longest receiver stalls, a 64-entry sort,
	// a long sender gap; about 250 items, then doubled.
	localparam int LIMIT_CYCLES  = 4_000_000;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata  = '0;   // [31:0] key
	logic [CMD_W-1:0]      s_tuser  = '0;   // [1:0] cmd
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [5:0] slot, [37:6] sorted_key
	logic [STAT_W-1:0]     m_tuser;         // [1:0] status
	logic                  m_tlast;

	int mismatches;
	int outstanding;
	int commands_sent = 0;
	int calm_sender   = 0;
	int stall_left    = 0;
	int calm_left     = 0;
	int cycle_count   = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	id_key_sorter uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	sort_result_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// Receiver pacing: mostly ready, short stalls, a few long ones, calm stretches.
	always @(posedge clk) begin : sink_pace
		int roll;
		if (stall_left > 0) begin
			stall_left = stall_left - 1;
			m_tready <= 1'b0;
		end else if (calm_left > 0) begin
			calm_left = calm_left - 1;
			m_tready <= 1'b1;
		end else begin
			roll = $urandom_range(0, 99);
			if (roll < 6) begin
				calm_left = $urandom_range(20, 80);
				m_tready <= 1'b1;
			end else if (roll < 30) begin
				stall_left = $urandom_range(0, 2);
				m_tready <= 1'b0;
			end else if (roll < 34) begin
				stall_left = $urandom_range(10, 40);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= LIMIT_CYCLES) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic int sender_gap();
		int roll;
		if (calm_sender > 0) begin
			calm_sender--;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 5) begin
			calm_sender = $urandom_range(10, 30);
			return 0;
		end
		if (roll < 50)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 96)
			return $urandom_range(4, 8);
		return $urandom_range(15, 40);
	endfunction

	// Mix of extremes, near-equal values for ties, and plain random keys.
	function automatic logic [KEY_W-1:0] pick_key();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return KEY_W'($urandom_range(0, 3));
			3: return {1'b1, (KEY_W-1)'($urandom_range(0, 3))};
			default: return $urandom();
		endcase
	endfunction

	// Hold valid across back-to-back commands; drop it only for a gap.
	task automatic issue(logic [CMD_W-1:0] cmd, logic [KEY_W-1:0] key);
		int gap;
		gap = sender_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= IN_DATA_W'(key);
		do begin
			@(posedge clk);
		end while (!s_tready);
		if (cmd != CMD_UNUSED)
			commands_sent++;
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		do begin
			@(posedge clk);
		end while (outstanding != 0);
	endtask

	initial begin
		int burst;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(CMD_SORT, '0);                 // empty store
		issue(CMD_ADD, 32'hFFFF_FFFF);
		issue(CMD_ADD, 32'h0000_0000);
		issue(CMD_SORT, '1);                 // two entries, reversed
		issue(CMD_ADD, 32'h8000_0000);
		issue(CMD_ADD, 32'h0000_0000);       // tie with slot 1
		issue(CMD_ADD, 32'hFFFF_FFFF);       // tie with slot 0
		issue(CMD_SORT, '0);
		issue(CMD_SORT, '0);                 // store unchanged by sorting
		issue(CMD_UNUSED, $urandom());
		issue(CMD_SORT, '0);
		issue(CMD_CLEAR, '1);
		issue(CMD_SORT, '0);
		issue(CMD_ADD, 32'h5555_5555);
		issue(CMD_SORT, '0);                 // single entry
		issue(CMD_CLEAR, '0);
		issue(CMD_CLEAR, '0);                // clear of an empty store
		issue(CMD_ADD, 32'hAAAA_AAAA);
		issue(CMD_ADD, 32'h0000_0001);
		issue(CMD_SORT, '0);
		issue(CMD_CLEAR, '0);
		drain_results();

		// Fill to capacity, overflow twice, sort the full store.
		for (int i = 0; i < MAX_ENTRIES; i++)
			issue(CMD_ADD, pick_key());
		issue(CMD_ADD, '1);
		issue(CMD_ADD, $urandom());
		issue(CMD_SORT, '0);
		issue(CMD_CLEAR, '0);
		drain_results();

		while (commands_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 85) begin
				burst = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 20)
					: $urandom_range(0, 5);
				repeat (burst) issue(CMD_ADD, pick_key());
				issue(CMD_SORT, $urandom());
				if ($urandom_range(0, 1) == 1)
					issue(CMD_CLEAR, $urandom());
			end else begin
				issue(CMD_W'($urandom_range(0, 3)), $urandom());
			end
			if ($urandom_range(0, 30) == 0)
				drain_results();
		end

		drain_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
